// File: rtl/mrfb_pkg.sv
`default_nettype none

package mrfb_pkg;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_WRITE   = 2'd0;
    localparam t_func FUNC_READ    = 2'd1;
    localparam t_func FUNC_QUERY   = 2'd2;
    localparam t_func FUNC_ADVANCE = 2'd3;

    // item field widths
    localparam int RING_FW   = 3;
    localparam int OFFS_W    = 8;
    localparam int IDX_W     = 6;
    localparam int SAMPLE_FW = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // available count, saturating
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // slot sums (slot + offset or slot + count) stay below 512
    localparam int NUM_W     = 9;
    localparam int MOD_SHIFT = 18;

    typedef logic [CNT_W-1:0] t_count;

endpackage

`default_nettype wire

// File: rtl/mrfb_mod_unit.sv
`default_nettype none

// two-stage reduction of a slot sum modulo FRAMES by reciprocal multiply
module mrfb_mod_unit #(
    parameter int FRAMES = 30,
    parameter int SLOT_W = 5
) (
    input  wire logic                          i_clk,
    input  wire logic [mrfb_pkg::NUM_W-1:0]    i_num,
    output logic      [SLOT_W-1:0]             o_rem
);

    localparam int NW     = mrfb_pkg::NUM_W;
    localparam int PROD_W = mrfb_pkg::NUM_W + mrfb_pkg::MOD_SHIFT;
    localparam int RECIP  = (2 ** mrfb_pkg::MOD_SHIFT + FRAMES - 1) / FRAMES;

    logic [PROD_W-1:0] w_prod;
    logic [NW-1:0]     w_diff;
    logic [NW-1:0]     r_num;
    logic [NW-1:0]     r_q;
    logic [SLOT_W-1:0] r_rem;

    // quotient is exact for every sum below 512
    assign w_prod = PROD_W'(i_num) * PROD_W'(RECIP);
    assign w_diff = r_num - r_q * NW'(FRAMES);

    always_ff @(posedge i_clk) begin
        r_num <= i_num;
        r_q   <= NW'(w_prod >> mrfb_pkg::MOD_SHIFT);
        r_rem <= SLOT_W'(w_diff);
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

// File: rtl/mrfb_ring_table.sv
`default_nettype none

// per-ring head, tail and count; entries read as zero until first written
module mrfb_ring_table #(
    parameter int NUM_RINGS = 8,
    parameter int RING_W    = 3,
    parameter int ENTRY_W   = 18
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [RING_W-1:0]   i_rd_addr,
    output logic      [ENTRY_W-1:0]  o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [RING_W-1:0]   i_wr_addr,
    input  wire logic [ENTRY_W-1:0]  i_wr_data
);

    logic [ENTRY_W-1:0]   r_mem [NUM_RINGS];
    logic [NUM_RINGS-1:0] r_valid;
    logic [ENTRY_W-1:0]   r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write data is forwarded when the same entry is read in that cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else if (r_valid[i_rd_addr]) begin
            r_rd_data <= r_mem[i_rd_addr];
        end else begin
            r_rd_data <= '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/mrfb_sample_ram.sv
`default_nettype none

module mrfb_sample_ram #(
    parameter int DEPTH  = 15360,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic               i_re,
    input  wire logic [ADDR_W-1:0]  i_addr,
    input  wire logic [DATA_W-1:0]  i_wdata,
    output logic      [DATA_W-1:0]  o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/multi_ring_frame_buffer.sv
`default_nettype none

// multi-ring frame buffer: NUM_RINGS rings of FRAMES frames, BLOCK_SIZE samples each.
// input stream: tuser = func (write, read, query, advance all), tlast = frame_end,
// tdata = ring, frame_offset, sample_index, sample_in. every item gives exactly
// one output transfer: sample_out, frame_count, has_room.
// items are worked one at a time; tready is high only while no item is in work.
// states an item passes through, in order: query LOOK, OUT; write LOOK, BASE, ADDR,
// MEM, OUT; read LOOK, MOD1, MOD2, BASE, ADDR, MEM, RDATA, OUT; advance all LOOK, MOD1,
// MOD2 for each ring, then OUT. the ring table and sample ram reads are registered
// and the modulo unit has two stages. the next item is taken in the cycle after the
// output register is loaded.
// the output register holds a finished result while the receiver stalls; the next
// item is accepted and worked meanwhile and waits only to load its own result.
// reset (synchronous, active low) clears every head, tail and count through the
// ring table valid bits at once; no clearing pass. sample words read before they
// were written are undefined.
module multi_ring_frame_buffer #(
    parameter int NUM_RINGS    = 8,
    parameter int FRAMES       = 30,
    parameter int BLOCK_SIZE   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ring[2:0], frame_offset[10:3], sample_index[16:11], sample_in[48:17], zeros above
    input  wire logic [55:0]  s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // sample_out[31:0], frame_count[39:32], has_room[40], zeros above
    output logic      [47:0]  m_axis_tdata
);

    localparam int RING_W      = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int SLOT_W      = $clog2(FRAMES);
    localparam int CW          = mrfb_pkg::CNT_W;
    localparam int ENTRY_W     = 2 * SLOT_W + CW;
    localparam int MEM_W       = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
    localparam int STORE_DEPTH = NUM_RINGS * FRAMES * BLOCK_SIZE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BASE_W      = $clog2(NUM_RINGS * FRAMES);
    localparam int NW          = mrfb_pkg::NUM_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_MOD1  = 4'd2;
    localparam logic [3:0] S_MOD2  = 4'd3;
    localparam logic [3:0] S_BASE  = 4'd4;
    localparam logic [3:0] S_ADDR  = 4'd5;
    localparam logic [3:0] S_MEM   = 4'd6;
    localparam logic [3:0] S_RDATA = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                       r_state, n_state;
    mrfb_pkg::t_func                  r_func;
    logic [mrfb_pkg::RING_FW-1:0]     r_ring;
    logic [mrfb_pkg::OFFS_W-1:0]      r_offs;
    logic [mrfb_pkg::IDX_W-1:0]       r_idx;
    logic [mrfb_pkg::SAMPLE_FW-1:0]   r_sin;
    logic                             r_fend;
    logic [SLOT_W-1:0]                r_head;
    logic [SLOT_W-1:0]                r_slot;
    logic [BASE_W-1:0]                r_base;
    logic [ADDR_W-1:0]                r_addr;
    logic [RING_W-1:0]                r_walk;
    logic [31:0]                      r_res_sample;
    mrfb_pkg::t_count                 r_res_count;
    logic                             r_res_room;
    logic                             r_out_valid;
    logic [31:0]                      r_out_sample;
    mrfb_pkg::t_count                 r_out_count;
    logic                             r_out_room;

    logic                             w_accept;
    logic                             w_ring_ok;
    logic                             w_idx_ok;
    logic                             w_walk_last;
    logic                             w_out_load;
    logic [ENTRY_W-1:0]               w_rd_entry;
    logic [SLOT_W-1:0]                w_rd_head;
    logic [SLOT_W-1:0]                w_rd_tail;
    mrfb_pkg::t_count                 w_rd_count;
    logic [SLOT_W-1:0]                w_new_head;
    mrfb_pkg::t_count                 w_new_count;
    mrfb_pkg::t_count                 w_look_count;
    logic [RING_W-1:0]                w_tbl_rd_addr;
    logic                             w_tbl_we;
    logic [RING_W-1:0]                w_tbl_wr_addr;
    logic [ENTRY_W-1:0]               w_tbl_wr_data;
    logic [NW-1:0]                    w_mod_num;
    logic [SLOT_W-1:0]                w_mod_rem;
    logic                             w_mem_we;
    logic                             w_mem_re;
    logic [MEM_W-1:0]                 w_mem_rdata;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_ring_ok   = 32'(r_ring) < NUM_RINGS;
    assign w_idx_ok    = 32'(r_idx) < BLOCK_SIZE;
    assign w_walk_last = r_walk == RING_W'(NUM_RINGS - 1);
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // table entry: head lowest, then tail, then count
    assign w_rd_head  = w_rd_entry[SLOT_W-1:0];
    assign w_rd_tail  = w_rd_entry[2*SLOT_W-1:SLOT_W];
    assign w_rd_count = w_rd_entry[ENTRY_W-1:2*SLOT_W];

    assign w_new_head  = (32'(w_rd_head) == FRAMES - 1) ? '0 : w_rd_head + 1'b1;
    assign w_new_count = (w_rd_count == mrfb_pkg::CNT_MAX) ? w_rd_count
                                                           : w_rd_count + 1'b1;
    assign w_look_count = ((r_func == mrfb_pkg::FUNC_WRITE) && r_fend) ? w_new_count
                                                                       : w_rd_count;

    always_comb begin
        w_tbl_rd_addr = RING_W'(r_ring);
        if (r_state == S_IDLE) begin
            w_tbl_rd_addr = (s_axis_tuser == mrfb_pkg::FUNC_ADVANCE) ? '0
                                                                      : RING_W'(s_axis_tdata[2:0]);
        end else if (r_state == S_MOD2) begin
            w_tbl_rd_addr = r_walk + 1'b1;
        end
    end

    always_comb begin
        w_tbl_we      = 1'b0;
        w_tbl_wr_addr = RING_W'(r_ring);
        w_tbl_wr_data = {w_new_count, w_rd_tail, w_new_head};
        if ((r_state == S_LOOK) && (r_func == mrfb_pkg::FUNC_WRITE) && w_ring_ok && r_fend) begin
            w_tbl_we = 1'b1;
        end else if ((r_state == S_MOD2) && (r_func == mrfb_pkg::FUNC_ADVANCE)) begin
            w_tbl_we      = 1'b1;
            w_tbl_wr_addr = r_walk;
            w_tbl_wr_data = {CW'(0), w_mod_rem, r_head};
        end
    end

    assign w_mod_num = (r_func == mrfb_pkg::FUNC_ADVANCE) ? NW'(w_rd_tail) + NW'(w_rd_count)
                                                          : NW'(w_rd_tail) + NW'(r_offs);

    assign w_mem_we = (r_state == S_MEM) && (r_func == mrfb_pkg::FUNC_WRITE) && w_idx_ok;
    assign w_mem_re = (r_state == S_MEM) && (r_func == mrfb_pkg::FUNC_READ);

    mrfb_ring_table #(
        .NUM_RINGS (NUM_RINGS),
        .RING_W    (RING_W),
        .ENTRY_W   (ENTRY_W)
    ) u_ring_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_tbl_rd_addr),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_tbl_we),
        .i_wr_addr (w_tbl_wr_addr),
        .i_wr_data (w_tbl_wr_data)
    );

    mrfb_mod_unit #(
        .FRAMES (FRAMES),
        .SLOT_W (SLOT_W)
    ) u_mod_unit (
        .i_clk (i_clk),
        .i_num (w_mod_num),
        .o_rem (w_mod_rem)
    );

    mrfb_sample_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (r_addr),
        .i_wdata (MEM_W'(r_sin)),
        .o_rdata (w_mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if ((r_func == mrfb_pkg::FUNC_ADVANCE)
                    || ((r_func == mrfb_pkg::FUNC_READ) && w_ring_ok)) begin
                    n_state = S_MOD1;
                end else if ((r_func == mrfb_pkg::FUNC_WRITE) && w_ring_ok) begin
                    n_state = S_BASE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MOD1: n_state = S_MOD2;
            S_MOD2: begin
                if (r_func != mrfb_pkg::FUNC_ADVANCE) begin
                    n_state = S_BASE;
                end else if (w_walk_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_BASE: n_state = S_ADDR;
            S_ADDR: n_state = S_MEM;
            S_MEM: begin
                n_state = (r_func == mrfb_pkg::FUNC_READ) ? S_RDATA : S_OUT;
            end
            S_RDATA: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_walk <= '0;
            end else if ((r_state == S_MOD2) && !w_walk_last) begin
                r_walk <= r_walk + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= s_axis_tuser;
            r_ring <= s_axis_tdata[2:0];
            r_offs <= s_axis_tdata[10:3];
            r_idx  <= s_axis_tdata[16:11];
            r_sin  <= s_axis_tdata[48:17];
            r_fend <= s_axis_tlast;
        end

        unique case (r_state)
            S_LOOK: begin
                r_head       <= w_rd_head;
                r_slot       <= w_rd_head;
                r_res_sample <= '0;
                r_res_count  <= w_ring_ok ? w_look_count : '0;
                r_res_room   <= w_ring_ok && (32'(w_look_count) < FRAMES);
            end
            S_MOD2: begin
                r_slot <= w_mod_rem;
                if (r_func == mrfb_pkg::FUNC_ADVANCE) begin
                    // after the advance every count is zero
                    r_res_count <= '0;
                    r_res_room  <= w_ring_ok;
                end
            end
            S_BASE: begin
                r_base <= BASE_W'(r_ring) * BASE_W'(FRAMES) + BASE_W'(r_slot);
            end
            S_ADDR: begin
                r_addr <= ADDR_W'(r_base) * ADDR_W'(BLOCK_SIZE) + ADDR_W'(r_idx);
            end
            S_RDATA: begin
                r_res_sample <= w_idx_ok ? 32'(w_mem_rdata) : '0;
            end
            default: begin
            end
        endcase
    end

    // output register parts the two sides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sample <= r_res_sample;
            r_out_count  <= r_res_count;
            r_out_room   <= r_res_room;
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_room, r_out_count, r_out_sample};

`ifndef SYNTHESIS
    a_accept_starts_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted item did not start a table lookup");

    a_table_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tbl_we |-> ((r_state == S_LOOK) || (r_state == S_MOD2)))
        else $error("ring table written outside lookup or modulo step");

    a_sample_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ((r_func == mrfb_pkg::FUNC_WRITE) && w_ring_ok && w_idx_ok))
        else $error("sample ram written by an item that stores nothing");

    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD2) |-> (32'(w_mod_rem) < FRAMES))
        else $error("modulo unit result not below frame count");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("result left the pipeline while the output was stalled");
`endif

endmodule

`default_nettype wire

// File: sim/multi_ring_frame_buffer_test.sv
`default_nettype none

module multi_ring_frame_buffer_test;

    localparam int RINGS      = 8;
    localparam int FRAMES     = 30;
    localparam int BLOCK      = 64;
    localparam int SWIDTH     = 32;
    localparam int STORE_SIZE = RINGS * FRAMES * BLOCK;
    localparam int ADV_CYCLES = 3 * RINGS + 1;
    localparam int ITEM_GOAL  = 1300;
    localparam int DRAIN_MAX  = 100000;

    typedef struct {
        bit [mrfb_pkg::SAMPLE_FW-1:0] sample;
        mrfb_pkg::t_count             count;
        bit                           room;
    } t_frame_result;

    class frame_ring_scoreboard;
        bit [mrfb_pkg::SAMPLE_FW-1:0] sample_mem [STORE_SIZE];
        bit                           sample_set [STORE_SIZE];
        int                           written_addr [$];
        int unsigned                  head_slot [RINGS];
        int unsigned                  tail_slot [RINGS];
        mrfb_pkg::t_count             avail [RINGS];
        t_frame_result                pending [$];
        int                           errors;
        int                           results_seen;
        int                           ops_seen [4];

        function int store_addr(int unsigned ring, int unsigned slot, int unsigned idx);
            return (ring * FRAMES + slot) * BLOCK + idx;
        endfunction

        function void note_transfer(mrfb_pkg::t_func func,
                                    logic [mrfb_pkg::RING_FW-1:0] ring,
                                    logic [mrfb_pkg::OFFS_W-1:0] offs,
                                    logic [mrfb_pkg::IDX_W-1:0] idx,
                                    logic [mrfb_pkg::SAMPLE_FW-1:0] word, logic fend);
            t_frame_result want;
            int            addr;
            int unsigned   slot;
            want.sample = '0;
            ops_seen[func]++;
            case (func)
                mrfb_pkg::FUNC_ADVANCE: begin
                    for (int i = 0; i < RINGS; i++) begin
                        tail_slot[i] = (tail_slot[i] + avail[i]) % FRAMES;
                        avail[i] = '0;
                    end
                end
                mrfb_pkg::FUNC_WRITE: begin
                    addr = store_addr(ring, head_slot[ring], idx);
                    sample_mem[addr] = word;
                    if (!sample_set[addr]) begin
                        sample_set[addr] = 1'b1;
                        written_addr.push_back(addr);
                    end
                    if (fend) begin
                        head_slot[ring] = (head_slot[ring] + 1) % FRAMES;
                        if (avail[ring] != mrfb_pkg::CNT_MAX) avail[ring]++;
                    end
                end
                mrfb_pkg::FUNC_READ: begin
                    slot = (tail_slot[ring] + offs) % FRAMES;
                    want.sample = sample_mem[store_addr(ring, slot, idx)];
                end
                default: ;
            endcase
            want.count = avail[ring];
            want.room  = avail[ring] < FRAMES;
            pending.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_transfer(logic [mrfb_pkg::M_TDATA_W-1:0] word);
            t_frame_result want;
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %0d came with nothing outstanding",
                                          results_seen));
                return;
            end
            want = pending.pop_front();
            if (word[31:0] !== want.sample)
                report_mismatch($sformatf("result %0d sample_out %h, want %h",
                                          results_seen, word[31:0], want.sample));
            if (word[39:32] !== want.count)
                report_mismatch($sformatf("result %0d frame_count %0d, want %0d",
                                          results_seen, word[39:32], want.count));
            if (word[40] !== want.room)
                report_mismatch($sformatf("result %0d has_room %b, want %b",
                                          results_seen, word[40], want.room));
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // ring[2:0], frame_offset[10:3], sample_index[16:11], sample_in[48:17], zeros above
    logic [mrfb_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // func[1:0]
    logic [1:0]                     s_axis_tuser = '0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // sample_out[31:0], frame_count[39:32], has_room[40], zeros above
    logic [mrfb_pkg::M_TDATA_W-1:0] m_axis_tdata;

    frame_ring_scoreboard sb = new();
    int items_sent;
    int burst_left;
    int stall_left;
    int stall_mode;
    int rx_cycle;

    multi_ring_frame_buffer #(
        .NUM_RINGS    (RINGS),
        .FRAMES       (FRAMES),
        .BLOCK_SIZE   (BLOCK),
        .SAMPLE_WIDTH (SWIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // receiver stalls: mode is drawn at random among free, coin flip and long holds
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 200 == 0) stall_mode = $urandom_range(0, 2);
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            case (stall_mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = 1'($urandom_range(0, 1));
                default: begin
                    m_axis_tready = 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_transfer(m_axis_tdata);
    end

    // one input transfer; bursts of random length separated by random gaps
    task automatic push_item(mrfb_pkg::t_func func, logic [mrfb_pkg::RING_FW-1:0] ring,
                             logic [mrfb_pkg::OFFS_W-1:0] offs,
                             logic [mrfb_pkg::IDX_W-1:0] idx,
                             logic [mrfb_pkg::SAMPLE_FW-1:0] word, logic fend);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, word, idx, offs, ring};
        s_axis_tuser  = func;
        s_axis_tlast  = fend;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_transfer(func, ring, offs, idx, word, fend);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_frame(logic [mrfb_pkg::RING_FW-1:0] ring);
        int len;
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++)
            push_item(mrfb_pkg::FUNC_WRITE, ring, 8'($urandom), 6'($urandom), $urandom,
                      j == len - 1);
    endtask

    // reads only ever target words that were written at some point
    task automatic read_written();
        int          addr;
        int unsigned ring, slot, idx, base;
        if (sb.written_addr.size() == 0) begin
            push_item(mrfb_pkg::FUNC_QUERY, 3'($urandom), 8'($urandom), 6'($urandom),
                      $urandom, 1'($urandom));
            return;
        end
        addr = sb.written_addr[$urandom_range(0, sb.written_addr.size() - 1)];
        ring = addr / (FRAMES * BLOCK);
        slot = (addr / BLOCK) % FRAMES;
        idx  = addr % BLOCK;
        base = (slot + FRAMES - sb.tail_slot[ring]) % FRAMES;
        base = base + FRAMES * $urandom_range(0, (255 - base) / FRAMES);
        push_item(mrfb_pkg::FUNC_READ, 3'(ring), 8'(base), 6'(idx), $urandom, 1'($urandom));
    endtask

    initial begin
        int  pick;
        int  waited;
        int  sat_ring;
        bit  sat_done;
        bit  timed_out;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        push_item(mrfb_pkg::FUNC_QUERY,   3'd0, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd0, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd0, 8'd255, 6'd63, 32'hFFFF_FFFF, 1'b1);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd7, 8'd0,   6'd0,  32'hA5A5_5A5A, 1'b1);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd2, 8'd0,   6'd42, 32'h1234_5678, 1'b0);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd2, 8'd0,   6'd21, 32'h8765_4321, 1'b1);
        push_item(mrfb_pkg::FUNC_READ,    3'd0, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_READ,    3'd0, 8'd0,   6'd63, 32'h0000_0000, 1'b0);
        // offsets past the frame count wrap around the ring
        push_item(mrfb_pkg::FUNC_READ,    3'd0, 8'd240, 6'd63, 32'h0000_0000, 1'b1);
        push_item(mrfb_pkg::FUNC_READ,    3'd2, 8'd120, 6'd42, 32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_READ,    3'd2, 8'd30,  6'd21, 32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_READ,    3'd7, 8'd0,   6'd0,  32'hFFFF_FFFF, 1'b0);
        push_item(mrfb_pkg::FUNC_QUERY,   3'd7, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_QUERY,   3'd5, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_ADVANCE, 3'd3, 8'd255, 6'd63, 32'hFFFF_FFFF, 1'b1);
        push_item(mrfb_pkg::FUNC_QUERY,   3'd0, 8'd0,   6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_READ,    3'd0, 8'd29,  6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_READ,    3'd7, 8'd239, 6'd0,  32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_WRITE,   3'd0, 8'd0,   6'd63, 32'h0000_0000, 1'b1);
        push_item(mrfb_pkg::FUNC_READ,    3'd0, 8'd0,   6'd63, 32'h0000_0000, 1'b0);
        push_item(mrfb_pkg::FUNC_ADVANCE, 3'd7, 8'd0,   6'd0,  32'h0000_0000, 1'b0);

        sat_done = 1'b0;
        while (items_sent < ITEM_GOAL) begin
            // one long run of committed frames drives a ring through full and saturation
            if (!sat_done && items_sent >= 600) begin
                sat_done = 1'b1;
                sat_ring = $urandom_range(0, RINGS - 1);
                for (int n = 0; n < 262; n++)
                    push_item(mrfb_pkg::FUNC_WRITE, 3'(sat_ring), 8'($urandom),
                              6'($urandom), $urandom, 1'b1);
                push_item(mrfb_pkg::FUNC_QUERY, 3'(sat_ring), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
                read_written();
                push_item(mrfb_pkg::FUNC_ADVANCE, 3'($urandom), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
                push_item(mrfb_pkg::FUNC_QUERY, 3'(sat_ring), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                write_frame(3'($urandom_range(0, RINGS - 1)));
            else if (pick < 70)
                repeat ($urandom_range(1, 6)) read_written();
            else if (pick < 80)
                push_item(mrfb_pkg::FUNC_QUERY, 3'($urandom), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
            else if (pick < 84)
                push_item(mrfb_pkg::FUNC_ADVANCE, 3'($urandom), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
            else
                push_item(mrfb_pkg::FUNC_WRITE, 3'($urandom), 8'($urandom), 6'($urandom),
                          $urandom, 1'($urandom));
        end
        s_axis_tvalid = 1'b0;

        waited = 0;
        timed_out = 1'b0;
        while (sb.pending.size() != 0 && !timed_out) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_MAX) timed_out = 1'b1;
        end
        repeat (ADV_CYCLES + 4) @(posedge i_clk);

        $display("sent %0d items: %0d writes, %0d reads, %0d queries, %0d advances",
                 items_sent, sb.ops_seen[mrfb_pkg::FUNC_WRITE],
                 sb.ops_seen[mrfb_pkg::FUNC_READ], sb.ops_seen[mrfb_pkg::FUNC_QUERY],
                 sb.ops_seen[mrfb_pkg::FUNC_ADVANCE]);
        $display("checked %0d results, %0d mismatches, %0d still outstanding",
                 sb.results_seen, sb.errors, sb.pending.size());
        if (sb.errors == 0 && !timed_out && sb.pending.size() == 0)
            $display("multi_ring_frame_buffer test passed");
        else
            $display("multi_ring_frame_buffer test failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout waiting for the block");
        $display("multi_ring_frame_buffer test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/mrfb_pkg.sv
rtl/mrfb_mod_unit.sv
rtl/mrfb_ring_table.sv
rtl/mrfb_sample_ram.sv
rtl/multi_ring_frame_buffer.sv
sim/multi_ring_frame_buffer_test.sv
